>>> rtl/core/midi_up_arpeggiator_defines.svh
// ----------------------------------------------------------------------------
// midi_up_arpeggiator_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef MIDI_UP_ARPEGGIATOR_DEFINES_SVH
`define MIDI_UP_ARPEGGIATOR_DEFINES_SVH

// same-cycle implication
`define MUA_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define MUA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/mua_pkg.sv
// ----------------------------------------------------------------------------
// mua_pkg
// types and codes of the up-arpeggiator note handler
// ----------------------------------------------------------------------------
package mua_pkg;

	localparam int NOTE_COUNT_DEF = 128;
	localparam int QUEUE_DEPTH    = 2;
	localparam int GROUP_W        = 16;
	localparam int VEL_W          = 7;
	localparam int CHAN_W         = 4;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 4;

	localparam logic [1:0] FUNC_ON   = 2'd0;
	localparam logic [1:0] FUNC_OFF  = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	localparam logic KIND_OFF = 1'b0;
	localparam logic KIND_ON  = 1'b1;

	localparam logic [1:0] TGT_SHARED = 2'd0;
	localparam logic [1:0] TGT_VOICE0 = 2'd1;
	localparam logic [1:0] TGT_VOICE1 = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOICE0 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOICE1 = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] note;
		logic [6:0] velocity;
		logic [3:0] midi_channel;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] target;
		logic [6:0] out_note;
		logic [6:0] out_velocity;
		logic       last;
		logic [7:0] held_total;
	} result_t;

	typedef enum logic [1:0] {
		OP_ON,
		OP_OFF,
		OP_TICK
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [6:0]        note;
		logic [VEL_W-1:0]  vel;
		logic [CHAN_W-1:0] chan;
	} cmd_t;

endpackage

>>> rtl/core/mua_front.sv
// ----------------------------------------------------------------------------
// mua_front
// accepts input items, folds zero-velocity note-ons into note-offs and drops
// items that do nothing before they reach the queue
// ----------------------------------------------------------------------------
module mua_front #(
	parameter int NOTE_COUNT = mua_pkg::NOTE_COUNT_DEF
) (
	input  logic           start,
	input  mua_pkg::item_t item,
	input  logic           mode,
	input  logic           q_full,
	output logic           busy,
	output logic           push,
	output mua_pkg::cmd_t  push_cmd
);
	import mua_pkg::*;

	logic accept;
	logic in_range;
	logic is_on;
	logic is_off;
	logic is_tick;

	assign busy     = q_full;
	assign accept   = start && !q_full;
	assign in_range = 9'(item.note) < 9'(NOTE_COUNT);
	assign is_on    = (item.func == FUNC_ON) && (item.velocity != '0);
	assign is_off   = (item.func == FUNC_OFF) ||
	                  ((item.func == FUNC_ON) && (item.velocity == '0));
	assign is_tick  = (item.func == FUNC_TICK) && mode;
	assign push     = accept && (((is_on || is_off) && in_range) || is_tick);

	always_comb begin
		if (is_tick) begin
			push_cmd.op = OP_TICK;
		end else if (is_on) begin
			push_cmd.op = OP_ON;
		end else begin
			push_cmd.op = OP_OFF;
		end
		push_cmd.note = item.note[6:0];
		push_cmd.vel  = item.velocity;
		push_cmd.chan = item.midi_channel;
	end

endmodule

>>> rtl/core/mua_queue.sv
// ----------------------------------------------------------------------------
// mua_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module mua_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mua_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          valid,
	output mua_pkg::cmd_t head
);
	import mua_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign valid = count_q != '0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/mua_back.sv
// ----------------------------------------------------------------------------
// mua_back
// held-note table, configuration registers, wraparound search and the
// sequencer that issues voice commands
// ----------------------------------------------------------------------------
module mua_back #(
	parameter int NOTE_COUNT = mua_pkg::NOTE_COUNT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	input  mua_pkg::cmd_t                         q_head,
	output logic                                  pop,
	input  logic                                  cfg_valid,
	input  logic [mua_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mua_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic                                  cfg_ready,
	output logic                                  mode,
	output logic                                  strobe,
	output mua_pkg::result_t                      result
);
	import mua_pkg::*;

	localparam int IDX_W = $clog2(NOTE_COUNT);
	localparam int HC_W  = $clog2(NOTE_COUNT + 1);
	localparam int GN    = (NOTE_COUNT + GROUP_W - 1) / GROUP_W;
	localparam int PW    = GN * GROUP_W;
	localparam int GI_W  = (GN > 1) ? $clog2(GN) : 1;
	localparam int LOC_W = $clog2(GROUP_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_PICK,
		ST_PLAY,
		ST_ON
	} state_t;

	state_t                   state_q;
	logic                     mode_q;
	logic [CHAN_W-1:0]        v0_q;
	logic [CHAN_W-1:0]        v1_q;
	logic [NOTE_COUNT-1:0]    bitmap_q;
	logic [HC_W-1:0]          cnt_q;
	logic                     step_valid_q;
	logic [IDX_W-1:0]         step_q;
	logic                     sound_valid_q;
	logic [IDX_W-1:0]         sound_q;
	logic [CHAN_W-1:0]        sound_chan_q;
	logic [IDX_W-1:0]         nx_q;
	logic                     strobe_q;
	result_t                  result_q;

	logic [VEL_W+CHAN_W-1:0]  tbl_mem [NOTE_COUNT];
	logic [VEL_W+CHAN_W-1:0]  rd_q;
	logic [GN-1:0]            up_any_q;
	logic [GN-1:0]            all_any_q;
	logic [LOC_W-1:0]         up_loc_q  [GN];
	logic [LOC_W-1:0]         all_loc_q [GN];

	logic [IDX_W-1:0]         head_idx;
	logic                     was_held;
	logic [HC_W-1:0]          cnt_inc;
	logic [HC_W-1:0]          cnt_dec;
	logic                     cfg_we;
	logic                     mem_we;
	logic [PW-1:0]            pad_vec;
	logic [PW-1:0]            up_vec;
	logic [GN-1:0]            up_any_d;
	logic [GN-1:0]            all_any_d;
	logic [LOC_W-1:0]         up_loc_d  [GN];
	logic [LOC_W-1:0]         all_loc_d [GN];
	logic                     use_up;
	logic [GN-1:0]            any_v;
	logic [GI_W-1:0]          sel_g;
	logic [LOC_W-1:0]         sel_loc;
	logic [GI_W+LOC_W-1:0]    nx_wide;
	logic [IDX_W-1:0]         nx_d;
	logic [VEL_W-1:0]         rd_vel;
	logic [CHAN_W-1:0]        rd_chan;

	function automatic logic [1:0] route(input logic [CHAN_W-1:0] ch,
	                                     input logic [CHAN_W-1:0] a,
	                                     input logic [CHAN_W-1:0] b);
		if (a == b) begin
			return TGT_SHARED;
		end
		return (ch == a) ? TGT_VOICE0 : TGT_VOICE1;
	endfunction

	function automatic result_t make_res(input logic       kd,
	                                     input logic [1:0] tg,
	                                     input logic [6:0] nt,
	                                     input logic [6:0] vl,
	                                     input logic       lst,
	                                     input logic [7:0] tot);
		result_t r;
		r.kind         = kd;
		r.target       = tg;
		r.out_note     = nt;
		r.out_velocity = vl;
		r.last         = lst;
		r.held_total   = tot;
		return r;
	endfunction

	assign head_idx  = q_head.note[IDX_W-1:0];
	assign was_held  = bitmap_q[head_idx];
	assign cnt_inc   = cnt_q + HC_W'(!was_held);
	assign cnt_dec   = cnt_q - HC_W'(was_held);
	assign pop       = (state_q == ST_IDLE) && q_valid;
	assign cfg_ready = (state_q == ST_IDLE) && !q_valid;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign mem_we    = pop && (q_head.op == OP_ON);
	assign mode      = mode_q;
	assign strobe    = strobe_q;
	assign result    = result_q;
	assign rd_vel    = rd_q[CHAN_W +: VEL_W];
	assign rd_chan   = rd_q[CHAN_W-1:0];

	// notes above the step pointer, then per-group first set bit
	always_comb begin
		pad_vec = PW'(bitmap_q);
		for (int i = 0; i < PW; i++) begin
			up_vec[i] = pad_vec[i] && (!step_valid_q || (i > int'(step_q)));
		end
		for (int g = 0; g < GN; g++) begin
			up_any_d[g]  = |up_vec[g*GROUP_W +: GROUP_W];
			all_any_d[g] = |pad_vec[g*GROUP_W +: GROUP_W];
			up_loc_d[g]  = '0;
			all_loc_d[g] = '0;
			for (int j = GROUP_W - 1; j >= 0; j--) begin
				if (up_vec[g*GROUP_W + j]) begin
					up_loc_d[g] = LOC_W'(j);
				end
				if (pad_vec[g*GROUP_W + j]) begin
					all_loc_d[g] = LOC_W'(j);
				end
			end
		end
	end

	// first group with a hit; wrap to the lowest held note when none above
	always_comb begin
		use_up = |up_any_q;
		any_v  = use_up ? up_any_q : all_any_q;
		sel_g  = '0;
		for (int g = GN - 1; g >= 0; g--) begin
			if (any_v[g]) begin
				sel_g = GI_W'(g);
			end
		end
		sel_loc = use_up ? up_loc_q[sel_g] : all_loc_q[sel_g];
		nx_wide = {sel_g, sel_loc};
		nx_d    = nx_wide[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIND) begin
			up_any_q  <= up_any_d;
			all_any_q <= all_any_d;
			up_loc_q  <= up_loc_d;
			all_loc_q <= all_loc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[head_idx] <= {q_head.vel, q_head.chan};
		end
		if (state_q == ST_PICK) begin
			rd_q <= tbl_mem[nx_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= 1'b0;
			v0_q          <= '0;
			v1_q          <= '0;
			bitmap_q      <= '0;
			cnt_q         <= '0;
			step_valid_q  <= 1'b0;
			step_q        <= '0;
			sound_valid_q <= 1'b0;
			sound_q       <= '0;
			sound_chan_q  <= '0;
			nx_q          <= '0;
			strobe_q      <= 1'b0;
			result_q      <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: begin
						if (cfg_data[0] != mode_q) begin
							mode_q        <= cfg_data[0];
							bitmap_q      <= '0;
							cnt_q         <= '0;
							step_valid_q  <= 1'b0;
							sound_valid_q <= 1'b0;
						end
					end
					REG_VOICE0: v0_q <= cfg_data;
					REG_VOICE1: v1_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						case (q_head.op)
							OP_ON: begin
								bitmap_q[head_idx] <= 1'b1;
								cnt_q              <= cnt_inc;
								if (!mode_q) begin
									strobe_q <= 1'b1;
									result_q <= make_res(KIND_ON,
										route(q_head.chan, v0_q, v1_q), q_head.note,
										q_head.vel, 1'b1, 8'(cnt_inc));
								end
							end
							OP_OFF: begin
								bitmap_q[head_idx] <= 1'b0;
								cnt_q              <= cnt_dec;
								if (!mode_q) begin
									strobe_q <= 1'b1;
									result_q <= make_res(KIND_OFF,
										route(q_head.chan, v0_q, v1_q), q_head.note,
										'0, 1'b1, 8'(cnt_dec));
								end else if (cnt_dec == '0 && sound_valid_q) begin
									strobe_q      <= 1'b1;
									result_q      <= make_res(KIND_OFF,
										route(sound_chan_q, v0_q, v1_q), 7'(sound_q),
										'0, 1'b1, '0);
									sound_valid_q <= 1'b0;
									step_valid_q  <= 1'b0;
								end
							end
							OP_TICK: begin
								if (cnt_q == '0) begin
									if (sound_valid_q) begin
										strobe_q <= 1'b1;
										result_q <= make_res(KIND_OFF,
											route(sound_chan_q, v0_q, v1_q), 7'(sound_q),
											'0, 1'b1, '0);
									end
									sound_valid_q <= 1'b0;
									step_valid_q  <= 1'b0;
								end else begin
									state_q <= ST_FIND;
								end
							end
							default: ;
						endcase
					end
				end
				ST_FIND: begin
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					nx_q    <= nx_d;
					state_q <= ST_PLAY;
				end
				ST_PLAY: begin
					strobe_q <= 1'b1;
					if (sound_valid_q) begin
						result_q <= make_res(KIND_OFF, route(sound_chan_q, v0_q, v1_q),
							7'(sound_q), '0, 1'b0, 8'(cnt_q));
						state_q  <= ST_ON;
					end else begin
						result_q      <= make_res(KIND_ON, route(rd_chan, v0_q, v1_q),
							7'(nx_q), rd_vel, 1'b1, 8'(cnt_q));
						sound_valid_q <= 1'b1;
						sound_q       <= nx_q;
						sound_chan_q  <= rd_chan;
						step_valid_q  <= 1'b1;
						step_q        <= nx_q;
						state_q       <= ST_IDLE;
					end
				end
				ST_ON: begin
					strobe_q      <= 1'b1;
					result_q      <= make_res(KIND_ON, route(rd_chan, v0_q, v1_q),
						7'(nx_q), rd_vel, 1'b1, 8'(cnt_q));
					sound_valid_q <= 1'b1;
					sound_q       <= nx_q;
					sound_chan_q  <= rd_chan;
					step_valid_q  <= 1'b1;
					step_q        <= nx_q;
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/midi_up_arpeggiator.sv
// ----------------------------------------------------------------------------
// midi_up_arpeggiator
// on/off items pass the queue, then result_q; one item per cycle unless busy
// with notes held, a tick walks the back through FIND, PICK, PLAY, ON if sounding
// the back end's search sequencer sets the tick rate; a 2-entry queue absorbs bursts
// async active-low reset clears the held bits, count and pointers at once, no sweep
// ----------------------------------------------------------------------------
module midi_up_arpeggiator #(
	parameter int NOTE_COUNT = mua_pkg::NOTE_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  mua_pkg::item_t                 item,
	output logic                           busy,
	output logic                           strobe,
	output mua_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mua_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mua_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mua_pkg::*;

	logic mode;
	logic q_full;
	logic q_valid;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t q_head;

	mua_front #(
		.NOTE_COUNT(NOTE_COUNT)
	) u_front (
		.start    (start),
		.item     (item),
		.mode     (mode),
		.q_full   (q_full),
		.busy     (busy),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mua_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.valid    (q_valid),
		.head     (q_head)
	);

	mua_back #(
		.NOTE_COUNT(NOTE_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.mode      (mode),
		.strobe    (strobe),
		.result    (result)
	);

endmodule

>>> rtl/core/mua_checker.sv
// ----------------------------------------------------------------------------
// mua_checker
// port-level checks on the arpeggiator, bound to the top level
// ----------------------------------------------------------------------------
`include "midi_up_arpeggiator_defines.svh"

module mua_checker #(
	parameter int NOTE_COUNT = mua_pkg::NOTE_COUNT_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             busy,
	input logic             strobe,
	input mua_pkg::result_t result,
	input logic             cfg_ready
);
	import mua_pkg::*;

	logic [7:0] note_limit;

	assign note_limit = 8'(NOTE_COUNT - 1);

	// a non-final command is the release of the sounding note
	`MUA_ASSERT_NOW(a_first_is_off, clk, arst_n, strobe && !result.last, result.kind == KIND_OFF && 8'(result.out_note) <= note_limit)

	// and the next note of the arpeggio follows right behind it
	`MUA_ASSERT_NEXT(a_pair_follows, clk, arst_n, strobe && !result.last, strobe && result.kind == KIND_ON && result.last)

	`MUA_ASSERT_NOW(a_off_silent, clk, arst_n, strobe && result.kind == KIND_OFF, result.out_velocity == '0)

	// a full queue means pending work, so configuration must wait
	`MUA_ASSERT_NOW(a_cfg_blocked, clk, arst_n, busy, !cfg_ready)

endmodule

bind midi_up_arpeggiator mua_checker #(
	.NOTE_COUNT(NOTE_COUNT)
) u_mua_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.busy      (busy),
	.strobe    (strobe),
	.result    (result),
	.cfg_ready (cfg_ready)
);

>>> sim/tb_midi_up_arpeggiator.sv
// ----------------------------------------------------------------------------
// tb_midi_up_arpeggiator
// self-checking bench for the up-arpeggiator note handler: a directed table
// covers live pass-through, voice routing, ignored items and the arp walk with
// wraparound and last release, then random phases under varied register
// settings and random idle gaps; every command is checked against the expected
// command of its directed row or a local model of the held-note table
// ----------------------------------------------------------------------------
module tb_midi_up_arpeggiator;
	timeunit 1ns;
	timeprecision 1ps;

	import mua_pkg::*;

	localparam int         N_NOTES       = NOTE_COUNT_DEF;
	localparam logic [7:0] NONE_NOTE     = 8'hFF;
	localparam logic [1:0] FUNC_NONE     = 2'd3;
	localparam logic [1:0] REG_SPARE     = 2'd3;
	localparam int         SETTLE_CYCLES = 24;
	localparam int         PHASES        = 8;
	localparam int         PHASE_ITEMS   = 56;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		item_t                 it;
		bit                    typed;
		result_t               want;
	} drow_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	item_t                 item_d = '0;
	logic                  busy;
	logic                  strobe;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// model state
	logic       arp_mode = 1'b0;
	logic [3:0] voice0_ch = '0;
	logic [3:0] voice1_ch = '0;
	logic [6:0] held_vel [N_NOTES] = '{default: '0};
	logic [3:0] held_chan [N_NOTES] = '{default: '0};
	logic [7:0] held_cnt = '0;
	logic [7:0] step_ptr = NONE_NOTE;
	logic [7:0] sound_note = NONE_NOTE;
	logic [3:0] sound_chan = '0;

	result_t pending_cmds[$];
	int      fail_count = 0;
	drow_t   dir_rows[$];

	midi_up_arpeggiator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item_d),
		.busy      (busy),
		.strobe    (strobe),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report(input string msg);
		fail_count++;
		$display("%0t: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	function automatic logic [1:0] voice_of(input logic [3:0] ch);
		if (voice0_ch == voice1_ch) return TGT_SHARED;
		return (ch == voice0_ch) ? TGT_VOICE0 : TGT_VOICE1;
	endfunction

	function automatic result_t voice_cmd(input logic k, input logic [3:0] ch,
			input logic [7:0] nt, input logic [6:0] vel);
		result_t r;
		r = '0;
		r.kind = k;
		r.target = voice_of(ch);
		r.out_note = nt[6:0];
		r.out_velocity = vel;
		return r;
	endfunction

	task automatic predict_commands(input item_t it, output result_t res[2], output int n);
		logic [1:0] fn;
		int nt;
		int nx;
		int from;
		int i;
		int j;
		fn = it.func;
		nt = int'(it.note);
		n = 0;
		res[0] = '0;
		res[1] = '0;
		if (fn == FUNC_ON && it.velocity == 0) fn = FUNC_OFF;
		if (fn == FUNC_ON && nt < N_NOTES) begin
			if (held_vel[nt] == 0) held_cnt = held_cnt + 8'd1;
			held_vel[nt] = it.velocity;
			held_chan[nt] = it.midi_channel;
			if (!arp_mode) begin
				res[n] = voice_cmd(KIND_ON, it.midi_channel, 8'(nt), it.velocity);
				n++;
			end
		end else if (fn == FUNC_OFF && nt < N_NOTES) begin
			if (held_vel[nt] != 0) begin
				held_vel[nt] = '0;
				held_chan[nt] = '0;
				if (held_cnt != 0) held_cnt = held_cnt - 8'd1;
			end
			if (!arp_mode) begin
				res[n] = voice_cmd(KIND_OFF, it.midi_channel, 8'(nt), 7'd0);
				n++;
			end else if (held_cnt == 0 && sound_note != NONE_NOTE) begin
				res[n] = voice_cmd(KIND_OFF, sound_chan, sound_note, 7'd0);
				n++;
				sound_note = NONE_NOTE;
				step_ptr = NONE_NOTE;
			end
		end else if (fn == FUNC_TICK && arp_mode) begin
			if (held_cnt == 0) begin
				if (sound_note != NONE_NOTE) begin
					res[n] = voice_cmd(KIND_OFF, sound_chan, sound_note, 7'd0);
					n++;
					sound_note = NONE_NOTE;
				end
				step_ptr = NONE_NOTE;
			end else begin
				// wraparound search for the next higher held note
				from = (step_ptr == NONE_NOTE) ? 0 : int'(step_ptr) + 1;
				nx = -1;
				for (i = 0; i < N_NOTES; i++) begin
					j = (from + i) % N_NOTES;
					if (nx < 0 && held_vel[j] != 0) nx = j;
				end
				if (nx >= 0) begin
					if (sound_note != NONE_NOTE) begin
						res[n] = voice_cmd(KIND_OFF, sound_chan, sound_note, 7'd0);
						n++;
					end
					res[n] = voice_cmd(KIND_ON, held_chan[nx], 8'(nx), held_vel[nx]);
					n++;
					sound_note = 8'(nx);
					sound_chan = held_chan[nx];
					step_ptr = 8'(nx);
				end
			end
		end
		for (i = 0; i < n; i++) begin
			res[i].last = (i == n - 1);
			res[i].held_total = held_cnt;
		end
	endtask

	task automatic send_item(input item_t it, input int gap, input bit use_typed,
			input result_t typed);
		result_t res[2];
		int n;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		item_d <= it;
		do @(posedge clk); while (busy);
		predict_commands(it, res, n);
		if (use_typed) pending_cmds.push_back(typed);
		else for (int k = 0; k < n; k++) pending_cmds.push_back(res[k]);
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE: begin
				if (data[0] != arp_mode) begin
					for (int i = 0; i < N_NOTES; i++) begin
						held_vel[i] = '0;
						held_chan[i] = '0;
					end
					held_cnt = '0;
					step_ptr = NONE_NOTE;
					sound_note = NONE_NOTE;
					arp_mode = data[0];
				end
			end
			REG_VOICE0: voice0_ch = data;
			REG_VOICE1: voice1_ch = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic drow_t row_item(input logic [1:0] f, input logic [7:0] nt,
			input logic [6:0] vel, input logic [3:0] ch);
		drow_t r;
		r = '{default: '0};
		r.it = '{func: f, note: nt, velocity: vel, midi_channel: ch};
		return r;
	endfunction

	function automatic drow_t row_chk(input logic [1:0] f, input logic [7:0] nt,
			input logic [6:0] vel, input logic [3:0] ch, input logic k,
			input logic [1:0] tgt, input logic [6:0] onote, input logic [6:0] ovel,
			input logic [7:0] held);
		drow_t r;
		r = row_item(f, nt, vel, ch);
		r.typed = 1'b1;
		r.want = '{kind: k, target: tgt, out_note: onote, out_velocity: ovel,
			last: 1'b1, held_total: held};
		return r;
	endfunction

	function automatic drow_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		drow_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (pending_cmds.size() == 0) begin
				report("command with nothing expected");
			end else begin
				want = pending_cmds.pop_front();
				check_field("kind", result.kind, want.kind);
				check_field("target", result.target, want.target);
				check_field("out_note", result.out_note, want.out_note);
				check_field("out_velocity", result.out_velocity, want.out_velocity);
				check_field("last", result.last, want.last);
				check_field("held_total", result.held_total, want.held_total);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		item_t      it;
		logic [7:0] pool [6];
		logic [3:0] v0;
		logic [3:0] v1;
		logic [3:0] mode_val;
		int         r;
		int         gap;
		bit         no_idle;

		dir_rows = '{
			row_chk(FUNC_ON, 8'd0, 7'd127, 4'd0, KIND_ON, TGT_SHARED, 7'd0, 7'd127, 8'd1),
			row_chk(FUNC_ON, 8'd127, 7'd1, 4'd15, KIND_ON, TGT_SHARED, 7'd127, 7'd1, 8'd2),
			row_item(FUNC_ON, 8'd128, 7'd5, 4'd0),
			row_item(FUNC_OFF, 8'd255, 7'd0, 4'd15),
			row_item(FUNC_NONE, 8'd255, 7'd127, 4'd15),
			row_item(FUNC_TICK, 8'd0, 7'd0, 4'd0),
			row_chk(FUNC_ON, 8'd0, 7'd0, 4'd9, KIND_OFF, TGT_SHARED, 7'd0, 7'd0, 8'd1),
			row_chk(FUNC_OFF, 8'd127, 7'd0, 4'd15, KIND_OFF, TGT_SHARED, 7'd127, 7'd0, 8'd0),
			row_chk(FUNC_OFF, 8'd50, 7'd33, 4'd4, KIND_OFF, TGT_SHARED, 7'd50, 7'd0, 8'd0),
			row_cfg(REG_VOICE0, 4'd3),
			row_cfg(REG_VOICE1, 4'd12),
			row_chk(FUNC_ON, 8'd60, 7'd64, 4'd3, KIND_ON, TGT_VOICE0, 7'd60, 7'd64, 8'd1),
			row_chk(FUNC_ON, 8'd61, 7'd100, 4'd12, KIND_ON, TGT_VOICE1, 7'd61, 7'd100, 8'd2),
			row_chk(FUNC_OFF, 8'd60, 7'd0, 4'd7, KIND_OFF, TGT_VOICE1, 7'd60, 7'd0, 8'd1),
			row_cfg(REG_MODE, 4'hF),
			row_item(FUNC_TICK, 8'd0, 7'd0, 4'd0),
			row_item(FUNC_ON, 8'd10, 7'd20, 4'd3),
			row_item(FUNC_ON, 8'd90, 7'd127, 4'd12),
			row_item(FUNC_TICK, 8'd0, 7'd0, 4'd0),
			row_item(FUNC_TICK, 8'd0, 7'd0, 4'd0),
			row_item(FUNC_TICK, 8'd0, 7'd0, 4'd0),
			row_item(FUNC_ON, 8'd127, 7'd0, 4'd0),
			row_item(FUNC_OFF, 8'd10, 7'd0, 4'd5),
			row_item(FUNC_OFF, 8'd90, 7'd0, 4'd5),
			row_item(FUNC_TICK, 8'd0, 7'd0, 4'd0),
			row_cfg(REG_MODE, 4'd1),
			row_cfg(REG_SPARE, 4'hF),
			row_cfg(REG_VOICE1, 4'd3),
			row_item(FUNC_ON, 8'd5, 7'd9, 4'd0),
			row_item(FUNC_TICK, 8'd0, 7'd0, 4'd0),
			row_cfg(REG_MODE, 4'd0),
			row_chk(FUNC_OFF, 8'd5, 7'd0, 4'd0, KIND_OFF, TGT_SHARED, 7'd5, 7'd0, 8'd0)
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				settle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_item(dir_rows[i].it, $urandom_range(0, 2), dir_rows[i].typed,
					dir_rows[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin v0 = 4'd0; v1 = 4'd0; end
				1: begin v0 = 4'd0; v1 = 4'd15; end
				2: begin v0 = 4'd15; v1 = 4'd0; end
				3: begin v0 = 4'd15; v1 = 4'd15; end
				default: begin v0 = 4'($urandom); v1 = 4'($urandom); end
			endcase
			mode_val = 4'($urandom);
			mode_val[0] = (p % 4 != 0);
			no_idle = (p % 3 == 1);
			settle();
			write_reg(REG_MODE, mode_val);
			write_reg(REG_VOICE0, v0);
			write_reg(REG_VOICE1, v1);
			foreach (pool[k]) pool[k] = 8'($urandom_range(0, 127));
			if (p % 2 == 0) pool[0] = 8'd0;
			else pool[5] = 8'd127;

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				it.note = pool[$urandom_range(0, 5)];
				it.velocity = 7'($urandom_range(0, 127));
				case ($urandom_range(0, 2))
					0: it.midi_channel = voice0_ch;
					1: it.midi_channel = voice1_ch;
					default: it.midi_channel = 4'($urandom);
				endcase
				if (r < 35) begin
					it.func = FUNC_ON;
					if ($urandom_range(0, 19) == 0) it.velocity = '0;
				end else if (r < 60) begin
					it.func = FUNC_OFF;
				end else if (r < 90) begin
					it.func = FUNC_TICK;
				end else begin
					// unused codes and out-of-range notes
					it = item_t'($urandom);
					if (it.func != FUNC_NONE) it.note[7] = 1'b1;
				end
				r = $urandom_range(0, 99);
				if (no_idle || r < 50) gap = 0;
				else if (r < 88) gap = $urandom_range(1, 3);
				else gap = $urandom_range(8, 30);
				send_item(it, gap, 1'b0, '0);
			end
		end

		settle();
		if (pending_cmds.size() != 0)
			report($sformatf("%0d commands never arrived", pending_cmds.size()));
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
